/* design/vlc_pkg.sv */
// Shared types, constants and the letter decoder of the letter cipher.
package vlc_pkg;

    // Key store geometry; the six-bit key index field covers the whole store.
    localparam int KEY_DEPTH  = 64;
    localparam int KEY_ADDR_W = $clog2(KEY_DEPTH);
    localparam int KEY_VAL_W  = 5;
    localparam int KEY_LEN_W  = 7;
    localparam int KEY_IDX_W  = 6;
    localparam int BYTE_W     = 8;

    localparam logic [5:0]        ALPHABET_SIZE = 6'd26;
    localparam logic [BYTE_W-1:0] LOWER_BASE    = 8'd96;
    localparam logic [BYTE_W-1:0] ASCII_SPACE   = 8'h20;

    // Configuration register indexes.
    localparam logic CFG_DECRYPT_MODE = 1'b0;
    localparam logic CFG_KEY_LENGTH   = 1'b1;

    // Input item operations.
    localparam logic OP_TEXT      = 1'b0;
    localparam logic OP_KEY_WRITE = 1'b1;

    typedef struct packed {
        logic                 is_letter;
        logic                 is_space;
        logic [KEY_VAL_W-1:0] value;
    } letter_code_t;

    // Letters of either case map to 1..26, which are the low five bits of
    // their ASCII code; a space maps to 0.
    function automatic letter_code_t letter_decode(input logic [BYTE_W-1:0] b);
        letter_code_t code;
        code.is_letter = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
        code.is_space  = (b == ASCII_SPACE);
        code.value     = b[KEY_VAL_W-1:0];
        return code;
    endfunction

endpackage

/* design/vlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/vlc_shift_unit.sv */
// Letter shift: adds or subtracts the key value and wraps within 1..26.
module vlc_shift_unit
    import vlc_pkg::*;
(
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic [KEY_VAL_W-1:0] key_value,
    input  logic                 decrypt,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 invalid
);

    letter_code_t code;
    logic [5:0]   sum;
    logic [5:0]   shifted;

    always_comb begin
        code = letter_decode(text_byte);
        sum  = 6'd0;
        if (decrypt) begin
            // Subtract, borrowing one alphabet length when the key is not smaller.
            if (code.value > key_value) begin
                sum = {1'b0, code.value} - {1'b0, key_value};
            end else begin
                sum = {1'b0, code.value} + ALPHABET_SIZE - {1'b0, key_value};
            end
            shifted = sum;
        end else begin
            sum = {1'b0, code.value} + {1'b0, key_value};
            shifted = (sum > ALPHABET_SIZE) ? (sum - ALPHABET_SIZE) : sum;
        end

        if (code.is_letter) begin
            out_byte = {2'b00, shifted} + LOWER_BASE;
            invalid  = 1'b0;
        end else if (code.is_space) begin
            out_byte = ASCII_SPACE;
            invalid  = 1'b0;
        end else begin
            out_byte = text_byte;
            invalid  = 1'b1;
        end
    end

endmodule

/* design/vigenere_letter_cipher.sv */
// Top level of the Vigenere-style letter cipher with its key store and pipeline.
// Pipeline: a text transaction passes from the input through stage one into the
// result register on m_*; a key write transaction produces no result.
// Throughput: one input transaction per cycle while the result side is not stalled;
// the single key store read port is read once per text byte; configuration writes are always accepted.
// Reset (aresetn, synchronous, active low) clears the pipeline valids, the key
// position, decrypt_mode and sets key_length to 1; the key store is not cleared.
module vigenere_letter_cipher
    import vlc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic [KEY_IDX_W-1:0] s_key_index,
    input  logic                 s_start_of_message,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    output logic                 m_invalid,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [KEY_LEN_W-1:0] cfg_data
);

    // Configuration registers.
    logic                  decrypt_mode_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;

    // Current key position, advanced by every text transaction.
    logic [KEY_ADDR_W-1:0] key_position_reg;
    logic [KEY_ADDR_W-1:0] key_position_next;

    // Stage one holds the text byte while the key store read completes.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [BYTE_W-1:0]     s1_byte_reg;

    // Result register.
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [BYTE_W-1:0]     m_out_byte_reg;
    logic                  m_invalid_reg;

    logic                  s1_fire;
    logic                  in_fire;
    logic                  text_fire;
    logic                  key_fire;
    logic                  cfg_fire;

    logic [KEY_LEN_W-1:0]  len_eff;
    logic [KEY_ADDR_W-1:0] pos_start;
    logic [KEY_ADDR_W-1:0] pos_sel;
    logic [KEY_LEN_W-1:0]  pos_inc;

    letter_code_t          key_code;
    logic [KEY_VAL_W-1:0]  key_wr_value;
    logic                  key_wr_en;
    logic [KEY_VAL_W-1:0]  key_rd_value;

    logic [BYTE_W-1:0]     shift_byte;
    logic                  shift_invalid;

    // Stage one drains into the result register when that register is empty
    // or its transaction is being taken in the same cycle.
    assign s1_fire   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_fire;
    assign in_fire   = s_valid && s_ready;
    assign text_fire = in_fire && (s_op == OP_TEXT);
    assign key_fire  = in_fire && (s_op == OP_KEY_WRITE);

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Effective key length is clamped into 1..KEY_DEPTH.
    always_comb begin
        if (key_length_reg == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (key_length_reg > KEY_LEN_W'(KEY_DEPTH)) begin
            len_eff = KEY_LEN_W'(KEY_DEPTH);
        end else begin
            len_eff = key_length_reg;
        end
    end

    // The start flag restarts the key; a position left beyond a shortened key
    // also restarts from entry zero.
    always_comb begin
        pos_start = s_start_of_message ? '0 : key_position_reg;
        pos_sel   = ({1'b0, pos_start} >= len_eff) ? '0 : pos_start;
        pos_inc   = {1'b0, pos_sel} + KEY_LEN_W'(1);
        key_position_next = (pos_inc >= len_eff) ? '0 : pos_inc[KEY_ADDR_W-1:0];
    end

    // Key bytes other than letters are stored as zero, the same as a space.
    always_comb begin
        key_code     = letter_decode(s_data_byte);
        key_wr_value = key_code.is_letter ? key_code.value : '0;
        key_wr_en    = key_fire && ({1'b0, s_key_index} < KEY_LEN_W'(KEY_DEPTH));
    end

    // The key store is read at the edge that accepts the text byte, so the
    // key value lines up with the byte held in stage one.
    vlc_ram #(
        .WIDTH (KEY_VAL_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (s_key_index[KEY_ADDR_W-1:0]),
        .wr_data (key_wr_value),
        .rd_en   (text_fire),
        .rd_addr (pos_sel),
        .rd_data (key_rd_value)
    );

    vlc_shift_unit u_shift (
        .text_byte (s1_byte_reg),
        .key_value (key_rd_value),
        .decrypt   (decrypt_mode_reg),
        .out_byte  (shift_byte),
        .invalid   (shift_invalid)
    );

    always_comb begin
        if (text_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_mode_reg <= 1'b0;
            key_length_reg   <= KEY_LEN_W'(1);
            key_position_reg <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                    CFG_KEY_LENGTH:   key_length_reg   <= cfg_data;
                    default:          key_length_reg   <= key_length_reg;
                endcase
            end
            if (text_fire) begin
                key_position_reg <= key_position_next;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (text_fire) begin
            s1_byte_reg <= s_data_byte;
        end
        if (s1_fire) begin
            m_out_byte_reg <= shift_byte;
            m_invalid_reg  <= shift_invalid;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_invalid  = m_invalid_reg;

`ifndef SYNTHESIS
    // A byte in stage one always moves into the result register when it is free.
    a_s1_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("stage one transaction did not reach the result register");

    // A stalled result keeps its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=>
            (m_valid_reg && $stable(m_out_byte_reg) && $stable(m_invalid_reg)))
        else $error("stalled result changed");

    // A key write never leaves a transaction in stage one.
    a_key_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        key_fire |=> !s1_valid_reg)
        else $error("key write created a pending text transaction");

    // The key position only moves on a text transaction.
    a_position_moves_on_text: assert property (@(posedge aclk) disable iff (!aresetn)
        !text_fire |=> $stable(key_position_reg))
        else $error("key position changed without a text transaction");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the Vigenere letter cipher: predictor class, drivers and checks.
`timescale 1ns / 1ps

module tb_top;
    import vlc_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 4;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Covers the two-stage pipeline, with margin, for key writes that give no result.
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 65;
    localparam int LETTERS       = 26;
    localparam int MAX_REPORTS   = 10;

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;

    // One expected result of a text transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] letter;
        logic              bad;
    } cipher_out_t;

    // Tracks the cipher state as seen through accepted transactions and
    // holds the results that are still owed by the block, oldest first.
    class vigenere_tracker;
        logic [KEY_VAL_W-1:0] shift_table [KEY_DEPTH];
        int                   position;
        logic                 decrypt;
        logic [KEY_LEN_W-1:0] length_reg;
        cipher_out_t          pending_letters [$];
        int                   mismatch_count;

        function new();
            foreach (shift_table[i]) shift_table[i] = '0;
            position       = 0;
            decrypt        = 1'b0;
            length_reg     = 7'd1;
            mismatch_count = 0;
        endfunction

        function void set_register(logic idx, logic [KEY_LEN_W-1:0] data);
            if (idx == CFG_DECRYPT_MODE) decrypt = data[0];
            else length_reg = data;
        endfunction

        // Letters of either case rank 1..26, a space ranks 0, anything else -1.
        function int letter_rank(logic [BYTE_W-1:0] b);
            if (b >= CHAR_LOWER_A && b < CHAR_LOWER_A + LETTERS) return b - CHAR_LOWER_A + 1;
            if (b >= CHAR_UPPER_A && b < CHAR_UPPER_A + LETTERS) return b - CHAR_UPPER_A + 1;
            if (b == ASCII_SPACE) return 0;
            return -1;
        endfunction

        function void take_byte(logic op, logic [BYTE_W-1:0] b,
                                logic [KEY_IDX_W-1:0] idx, logic som);
            int          span;
            int          slot;
            int          shift;
            int          rank;
            int          sum;
            cipher_out_t res;
            rank = letter_rank(b);
            if (op == OP_KEY_WRITE) begin
                shift_table[idx] = (rank < 0) ? '0 : rank[KEY_VAL_W-1:0];
                return;
            end
            if (length_reg == 0) span = 1;
            else if (length_reg > KEY_DEPTH) span = KEY_DEPTH;
            else span = int'(length_reg);
            slot = som ? 0 : position;
            if (slot >= span) slot = 0;
            shift = int'(shift_table[slot]);
            res.bad = 1'b0;
            if (rank < 0) begin
                res.letter = b;
                res.bad    = 1'b1;
            end else if (rank == 0) begin
                res.letter = ASCII_SPACE;
            end else begin
                if (decrypt) begin
                    sum = (rank > shift) ? rank - shift : rank + LETTERS - shift;
                end else begin
                    sum = rank + shift;
                    if (sum > LETTERS) sum -= LETTERS;
                end
                res.letter = 8'(sum) + LOWER_BASE;
            end
            position = (slot + 1 >= span) ? 0 : slot + 1;
            pending_letters.push_back(res);
        endfunction

        function void match_letter(logic [BYTE_W-1:0] b, logic bad);
            cipher_out_t want;
            if (pending_letters.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: out_byte %h invalid %b", b, bad);
                return;
            end
            want = pending_letters.pop_front();
            if (b !== want.letter || bad !== want.bad) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: expected out_byte %h invalid %b, got out_byte %h invalid %b",
                             want.letter, want.bad, b, bad);
            end
        endfunction

        function int waiting();
            return pending_letters.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_op;
    logic [BYTE_W-1:0]    s_data_byte;
    logic [KEY_IDX_W-1:0] s_key_index;
    logic                 s_start_of_message;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_invalid;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [KEY_LEN_W-1:0] cfg_data;

    vigenere_tracker tracker;

    // Key entries that have been written so far. Text is only sent when
    // every entry inside the current key length has been written, so the
    // block never reads an entry whose contents are undefined.
    bit key_written [KEY_DEPTH];

    // Receiver behavior, set per phase by the stimulus process.
    int stall_pct   = 0;
    int holds_asked = 0;
    int quiet_cycles = 0;

    vigenere_letter_cipher i_dut (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // Monitors: everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so the order of processes
    // within the time step does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_byte(s_op, s_data_byte, s_key_index, s_start_of_message);
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_index, cfg_data);
            if (m_valid && m_ready)
                tracker.match_letter(m_out_byte, m_invalid);
        end
    end

    // Watchdog: a run in which no transaction of any channel completes for
    // a long time is hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: ready is held for runs of random length, low with the
    // probability of the current phase. When a long hold is asked for, the
    // receiver holds ready low while the sender keeps offering transactions,
    // so the pipeline fills and input backpressure shows up on s_ready.
    initial begin : result_sink
        int holds_done;
        int run;
        holds_done = 0;
        forever begin
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                m_ready <= 1'b0;
                run = HOLD_CYCLES;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
                run = $urandom_range(1, 12);
            end
            repeat (run) @(posedge aclk);
        end
    end

    // Offers one input transaction and returns at the edge that takes it.
    // Valid stays high afterwards, so back-to-back calls form a burst.
    task automatic send_item(logic op, logic [BYTE_W-1:0] b,
                             logic [KEY_IDX_W-1:0] idx, logic som);
        s_valid            <= 1'b1;
        s_op               <= op;
        s_data_byte        <= b;
        s_key_index        <= idx;
        s_start_of_message <= som;
        if (op == OP_KEY_WRITE) key_written[idx] = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Waits until every owed result has come back, then lets a trailing
    // key write, which gives no result, leave the pipeline as well.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.waiting() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers back to back; valid stays high between them.
    task automatic configure(logic decrypt, logic [KEY_LEN_W-1:0] span);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DECRYPT_MODE;
        cfg_data  <= {{(KEY_LEN_W-1){1'b0}}, decrypt};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_KEY_LENGTH;
        cfg_data  <= span;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random character: a share of arbitrary bytes, then spaces, lowercase
    // and uppercase letters.
    function automatic logic [BYTE_W-1:0] random_char(int other_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < other_pct) return 8'($urandom_range(0, 255));
        if (pick < other_pct + 15) return ASCII_SPACE;
        if (pick < other_pct + 55) return CHAR_LOWER_A + 8'($urandom_range(0, LETTERS - 1));
        return CHAR_UPPER_A + 8'($urandom_range(0, LETTERS - 1));
    endfunction

    // One phase of random traffic at a fixed key length. Most text comes
    // as messages that open with the start flag; some messages are cut
    // short by a stray start flag, and key writes are mixed in, either to
    // fill entries still missing for this key length or at random.
    task automatic run_phase(int items, int span, bit gaps_on);
        int                   burst;
        int                   missing;
        int                   pick;
        int                   msg_left;
        logic [BYTE_W-1:0]    b;
        logic [KEY_IDX_W-1:0] idx;
        logic                 som;
        burst    = $urandom_range(1, 30);
        msg_left = 0;
        for (int n = 0; n < items; n++) begin
            missing = -1;
            for (int e = span - 1; e >= 0; e--) begin
                if (!key_written[e]) missing = e;
            end
            pick = $urandom_range(0, 99);
            if (missing >= 0 || pick < 12) begin
                idx = (missing >= 0) ? 6'(missing) : 6'($urandom_range(0, KEY_DEPTH - 1));
                send_item(OP_KEY_WRITE, random_char(25), idx, 1'($urandom_range(0, 1)));
            end else begin
                som = (msg_left == 0) || ($urandom_range(0, 99) < 3);
                if (som) msg_left = $urandom_range(1, 40);
                msg_left--;
                b = random_char(12);
                send_item(OP_TEXT, b, 6'($urandom_range(0, KEY_DEPTH - 1)), som);
            end
            if (gaps_on) begin
                burst--;
                if (burst == 0) begin
                    pause_sender($urandom_range(1, 8));
                    burst = $urandom_range(1, 30);
                end
            end
        end
    endtask

    initial begin : stimulus
        int                   phase_lengths [RANDOM_PHASES];
        int                   span;
        logic [KEY_LEN_W-1:0] length_val;
        logic                 decrypt_val;
        bit                   gaps_on;
        phase_lengths = '{64, 64, 0, 127, 5, 17, 2, 1, 33, 9};
        tracker = new();
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_op               <= OP_TEXT;
        s_data_byte        <= '0;
        s_key_index        <= '0;
        s_start_of_message <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= CFG_DECRYPT_MODE;
        cfg_data           <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings: encrypt with a key of length
        // one. The first key write also carries the start flag, which the
        // block must ignore on a key write.
        send_item(OP_KEY_WRITE, "c", 6'd0, 1'b1);
        send_item(OP_TEXT, "a", 6'd0, 1'b1);
        // Wrap at the top of the alphabet, and both cases of both ends.
        send_item(OP_TEXT, "z", 6'd63, 1'b0);
        send_item(OP_TEXT, "A", 6'd0, 1'b0);
        send_item(OP_TEXT, "Z", 6'd0, 1'b0);
        send_item(OP_TEXT, " ", 6'd0, 1'b0);
        // Bytes just outside the letter ranges, and the byte extremes, pass
        // through with the invalid flag.
        send_item(OP_TEXT, 8'h00, 6'd0, 1'b0);
        send_item(OP_TEXT, 8'hFF, 6'd0, 1'b0);
        send_item(OP_TEXT, 8'h40, 6'd0, 1'b0);
        send_item(OP_TEXT, 8'h5B, 6'd0, 1'b0);
        send_item(OP_TEXT, 8'h60, 6'd0, 1'b0);
        send_item(OP_TEXT, 8'h7B, 6'd0, 1'b0);
        // A key of 26 maps every letter onto itself.
        send_item(OP_KEY_WRITE, "Z", 6'd0, 1'b0);
        send_item(OP_TEXT, "m", 6'd0, 1'b0);
        // A key byte that is no letter is stored like a space, as zero.
        send_item(OP_KEY_WRITE, "#", 6'd0, 1'b0);
        send_item(OP_TEXT, "q", 6'd0, 1'b0);
        send_item(OP_KEY_WRITE, " ", 6'd0, 1'b0);
        send_item(OP_TEXT, "K", 6'd0, 1'b0);
        send_item(OP_KEY_WRITE, "b", 6'd63, 1'b0);
        wait_idle();

        // Directed decrypt with a two-entry key, including a wrap below "a".
        configure(1'b1, 7'd2);
        send_item(OP_KEY_WRITE, "C", 6'd0, 1'b0);
        send_item(OP_KEY_WRITE, "b", 6'd1, 1'b0);
        send_item(OP_TEXT, "a", 6'd0, 1'b1);
        send_item(OP_TEXT, "b", 6'd0, 1'b0);
        send_item(OP_TEXT, "c", 6'd0, 1'b0);
        send_item(OP_TEXT, "Z", 6'd0, 1'b1);
        wait_idle();

        // Random phases. The key length walks through the full store, zero,
        // the top of the register range and small values; going from a long
        // key to a short one leaves a stale key position behind.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            decrypt_val = p[0];
            length_val  = 7'(phase_lengths[p]);
            if (p >= RANDOM_PHASES - 2) begin
                decrypt_val = 1'($urandom_range(0, 1));
                length_val  = 7'($urandom_range(0, 127));
            end
            if (length_val == 0) span = 1;
            else if (length_val > KEY_DEPTH) span = KEY_DEPTH;
            else span = int'(length_val);
            configure(decrypt_val, length_val);
            stall_pct = 25 * (p % 4);
            gaps_on   = (p % 3) != 0;
            // Two phases push the block into backpressure: the sender runs
            // without gaps while the receiver holds off.
            if (p == 1 || p == 6) begin
                gaps_on = 1'b0;
                holds_asked++;
            end
            run_phase(PHASE_ITEMS, span, gaps_on);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatch_count == 0 && tracker.waiting() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
